// ===== design/tlms_pkg.sv =====
// Shared types, codes and constants of the timed lift motor sequencer.
package tlms_pkg;

    // Request kinds carried in s_tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_LOWER = 1'b1;

    // Relay patterns, bit i drives relay Di
    localparam logic [3:0] RELAY_OFF   = 4'd0;
    localparam logic [3:0] RELAY_FWD   = 4'd9;
    localparam logic [3:0] RELAY_REV   = 4'd6;
    localparam logic [3:0] RELAY_BRAKE = 4'd12;

    typedef enum logic [1:0] {
        POS_UNKNOWN = 2'd0,
        POS_HIGH    = 2'd1,
        POS_LOW     = 2'd2
    } pos_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RETURN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERCURRENT = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  FWD_TICKS_RST   = 8'd20;
    localparam logic [7:0]  REV_TICKS_RST   = 8'd6;
    localparam logic        AUTO_RETURN_RST = 1'b1;
    localparam logic [15:0] DWELL_TICKS_RST = 16'd122;
    localparam logic [15:0] OVERCURRENT_RST = 16'd4000;

    // Sensor scaling: clamp to ADC_LO..ADC_HI, subtract ADC_LO, scale, re-center
    localparam logic [9:0]  ADC_LO        = 10'd102;
    localparam logic [9:0]  ADC_HI        = 10'd922;
    localparam logic [9:0]  ADC_LO_LIMIT  = 10'd103;
    localparam logic [9:0]  ADC_HI_LIMIT  = 10'd921;
    localparam logic [15:0] SCALE_MUL     = 16'd49951;
    localparam logic [16:0] MV_CENTER     = 17'd20000;

    typedef struct packed {
        logic [7:0]  fwd_ticks;
        logic [7:0]  rev_ticks;
        logic        auto_en;
        logic [15:0] dwell_ticks;
        logic [15:0] oc_mv;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  relay_drive;
        logic [1:0]  board_position;
        logic        busy_led;
        logic        ack_pulse;
        logic        done_pulse;
        logic [15:0] current_mv;
    } result_t;

endpackage

// ===== design/tlms_scale.sv =====
// Current sensor scaling: clamp, offset and scale a raw sample to millivolts.
module tlms_scale
    import tlms_pkg::*;
(
    input  logic [9:0]  adc_sample,
    output logic [15:0] current_mv
);

    logic [9:0]  clamped;
    logic [9:0]  offset;
    logic [25:0] prod;
    logic [16:0] centered;

    always_comb begin
        if (adc_sample < ADC_LO_LIMIT) begin
            clamped = ADC_LO;
        end else if (adc_sample > ADC_HI_LIMIT) begin
            clamped = ADC_HI;
        end else begin
            clamped = adc_sample;
        end
    end

    assign offset   = clamped - ADC_LO;
    assign prod     = {16'd0, offset} * {10'd0, SCALE_MUL};
    assign centered = {1'b0, prod[25:10]} - MV_CENTER;
    assign current_mv = centered[15:0];

endmodule

// ===== design/tlms_ctrl.sv =====
// Run sequencer: run state, counters and relay pattern, one update per item.
module tlms_ctrl
    import tlms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic        req_type,
    input  logic [15:0] current_mv,
    input  cfg_t        cfg,
    output result_t     result
);

    logic        fwd_reg, fwd_next;
    logic        rev_reg, rev_next;
    logic [15:0] cnt_reg, cnt_next;
    pos_t        pos_reg, pos_next;
    logic [15:0] dwell_reg, dwell_next;
    logic [3:0]  relay_reg, relay_next;
    logic        busy_reg, busy_next;
    logic        ack;
    logic        done;
    logic        over_thresh;

    assign over_thresh = $signed(current_mv) >= $signed(cfg.oc_mv);

    always_comb begin
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        dwell_next = dwell_reg;
        relay_next = relay_reg;
        busy_next  = busy_reg;
        ack        = 1'b0;
        done       = 1'b0;
        if (req_type == REQ_LOWER) begin
            // lower command restarts as reverse run; dwell count kept
            busy_next  = 1'b1;
            ack        = 1'b1;
            cnt_next   = 16'd0;
            pos_next   = POS_UNKNOWN;
            relay_next = RELAY_REV;
            rev_next   = 1'b1;
            fwd_next   = 1'b0;
        end else begin
            if (fwd_next) begin
                cnt_next = cnt_next + 16'd1;
                if (cnt_next >= {9'd0, cfg.fwd_ticks[7:1]} && over_thresh) begin
                    cnt_next = {8'd0, cfg.fwd_ticks};
                end
                if (cnt_next == {8'd0, cfg.fwd_ticks}) begin
                    pos_next   = POS_HIGH;
                    fwd_next   = 1'b0;
                    rev_next   = 1'b0;
                    cnt_next   = 16'd0;
                    relay_next = RELAY_BRAKE;
                    done       = 1'b1;
                    busy_next  = 1'b0;
                end
            end
            if (rev_next) begin
                cnt_next = cnt_next + 16'd1;
                if (cnt_next == {8'd0, cfg.rev_ticks}) begin
                    pos_next   = POS_LOW;
                    dwell_next = 16'd0;
                    fwd_next   = 1'b0;
                    rev_next   = 1'b0;
                    cnt_next   = 16'd0;
                    relay_next = RELAY_BRAKE;
                end
            end
            // dwell counts the tick on which the reverse run ended
            if (pos_next == POS_LOW && cfg.auto_en) begin
                dwell_next = dwell_next + 16'd1;
                if (dwell_next == cfg.dwell_ticks) begin
                    dwell_next = 16'd0;
                    cnt_next   = 16'd0;
                    pos_next   = POS_UNKNOWN;
                    relay_next = RELAY_FWD;
                    fwd_next   = 1'b1;
                    rev_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg   <= 1'b0;
            rev_reg   <= 1'b0;
            cnt_reg   <= 16'd0;
            pos_reg   <= POS_UNKNOWN;
            dwell_reg <= 16'd0;
            relay_reg <= RELAY_OFF;
            busy_reg  <= 1'b0;
        end else if (step_en) begin
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            dwell_reg <= dwell_next;
            relay_reg <= relay_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb begin
        result.relay_drive    = relay_next;
        result.board_position = pos_next;
        result.busy_led       = busy_next;
        result.ack_pulse      = ack;
        result.done_pulse     = done;
        result.current_mv     = (req_type == REQ_LOWER) ? 16'd0 : current_mv;
    end

endmodule

// ===== design/timed_lift_motor_sequencer_top.sv =====
// Top level of the timed lift motor sequencer: ports, config registers, stage registers.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata: adc_sample; tuser: req_type
//   m_       out  m_tvalid/m_tready  tdata: relay, position, busy, ack, done, current
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One beat in, one beat out; a beat passes through the input register and
// leaves through the output register, and a beat can enter every cycle while
// the output is not stalled. The sequencer state updates as a beat moves into the output
// register. A stalled output holds one result while one more beat waits in the
// input register. Synchronous active-low reset clears state and config.
module timed_lift_motor_sequencer_top
    import tlms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [9:0] adc_sample, [15:10] zero
    input  logic [0:0]           s_tuser,   // [0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [3:0] relay_drive, [5:4] board_position,
                                            // [6] busy_led, [7] ack_pulse,
                                            // [8] done_pulse, [24:9] current_mv, [31:25] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_type_reg;
    logic [9:0]  in_adc_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        advance;
    logic [15:0] current_mv;
    result_t     result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fwd_ticks   <= FWD_TICKS_RST;
            cfg_reg.rev_ticks   <= REV_TICKS_RST;
            cfg_reg.auto_en     <= AUTO_RETURN_RST;
            cfg_reg.dwell_ticks <= DWELL_TICKS_RST;
            cfg_reg.oc_mv       <= OVERCURRENT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FWD_TICKS:   cfg_reg.fwd_ticks   <= cfg_wdata[7:0];
                CFG_REV_TICKS:   cfg_reg.rev_ticks   <= cfg_wdata[7:0];
                CFG_AUTO_RETURN: cfg_reg.auto_en     <= cfg_wdata[0];
                CFG_DWELL_TICKS: cfg_reg.dwell_ticks <= cfg_wdata;
                CFG_OVERCURRENT: cfg_reg.oc_mv       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg <= s_tuser[0];
            in_adc_reg  <= s_tdata[9:0];
        end
    end

    tlms_scale u_scale (
        .adc_sample (in_adc_reg),
        .current_mv (current_mv)
    );

    tlms_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .req_type   (in_type_reg),
        .current_mv (current_mv),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_data_reg.current_mv,
                       out_data_reg.done_pulse,
                       out_data_reg.ack_pulse,
                       out_data_reg.busy_led,
                       out_data_reg.board_position,
                       out_data_reg.relay_drive};

endmodule

// ===== design/tlms_checker.sv =====
// Port-level checker for the timed lift motor sequencer, bound to the top level.
module tlms_checker
    import tlms_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [31:0]          m_tdata
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a lower command answers with reverse drive, unknown position, busy, zero current
    a_ack_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |->
            m_tdata[3:0] == RELAY_REV && m_tdata[5:4] == POS_UNKNOWN &&
            m_tdata[6] && m_tdata[24:9] == 16'd0 && !m_tdata[8])
        else $error("ack beat has wrong fields");

    // end of a raise run: braked, high, not busy
    a_done_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |->
            m_tdata[3:0] == RELAY_BRAKE && m_tdata[5:4] == POS_HIGH && !m_tdata[6])
        else $error("done beat has wrong fields");

    // a known position only ever shows with the relays braked
    a_pos_brake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5:4] == POS_HIGH || m_tdata[5:4] == POS_LOW) |->
            m_tdata[3:0] == RELAY_BRAKE)
        else $error("known position while relays not braked");

endmodule

bind timed_lift_motor_sequencer_top tlms_checker u_tlms_checker (.*);

// ===== sim/timed_lift_motor_sequencer_top_test.sv =====
// Self-checking testbench for the lift motor sequencer: directed table, random runs, gapless tail.
`timescale 1ns / 1ps

module timed_lift_motor_sequencer_top_test;
    import tlms_pkg::*;

    typedef struct packed {
        logic [3:0]         relay;
        pos_t               pos;
        logic               busy;
        logic               ack;
        logic               done;
        logic signed [15:0] mv;
    } lift_beat_t;

    typedef struct {
        bit          is_cfg;
        logic        req;
        logic [9:0]  adc;
        bit          typed;
        lift_beat_t  exp_v;
        logic [7:0]  f;
        logic [7:0]  r;
        logic        a;
        logic [15:0] d;
        logic [15:0] o;
    } plan_row_t;

    localparam lift_beat_t LOWER_ACK = '{RELAY_REV, POS_UNKNOWN, 1'b1, 1'b1, 1'b0, 16'sd0};
    localparam lift_beat_t BY_PREDICTOR = '{RELAY_OFF, POS_UNKNOWN, 1'b0, 1'b0, 1'b0, 16'sd0};

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_wdata;

    // predictor copy of the config registers and sequencer state
    logic [7:0]         cf_fwd   = FWD_TICKS_RST;
    logic [7:0]         cf_rev   = REV_TICKS_RST;
    logic               cf_auto  = AUTO_RETURN_RST;
    logic [15:0]        cf_dwell = DWELL_TICKS_RST;
    logic signed [15:0] cf_oc    = OVERCURRENT_RST;
    logic               fwd_on   = 1'b0;
    logic               rev_on   = 1'b0;
    logic [15:0]        run_cnt  = '0;
    logic [15:0]        dwell_cnt = '0;
    pos_t               pos_q    = POS_UNKNOWN;
    logic [3:0]         relay_q  = RELAY_OFF;
    logic               busy_q   = 1'b0;

    lift_beat_t expected_beats[$];
    plan_row_t  plan_q[$];

    int send_gap_pct = 0;
    int sink_gap_pct = 0;
    int stall_left = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int lowers_sent = 0;
    int raises_seen = 0;
    int settings_used = 0;
    int gap_choice[3] = '{0, 10, 30};

    timed_lift_motor_sequencer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic lift_beat_t predict_lift_beat(input logic req, input logic [9:0] adc);
        int unsigned s;
        int          mv;
        lift_beat_t  r;
        mv = 0;
        r.ack = 1'b0;
        r.done = 1'b0;
        if (req == REQ_LOWER) begin
            busy_q = 1'b1;
            r.ack = 1'b1;
            run_cnt = '0;
            pos_q = POS_UNKNOWN;
            relay_q = RELAY_REV;
            rev_on = 1'b1;
            fwd_on = 1'b0;
        end else begin
            s = adc;
            if (s < ADC_LO_LIMIT) begin
                s = ADC_LO;
            end else if (s > ADC_HI_LIMIT) begin
                s = ADC_HI;
            end
            mv = int'(((s - ADC_LO) * SCALE_MUL) >> 10) - 20000;
            if (fwd_on) begin
                run_cnt = run_cnt + 16'd1;
                // at or past half the run, overcurrent jumps straight to the end
                if (run_cnt >= (cf_fwd >> 1) && mv >= cf_oc) run_cnt = {8'd0, cf_fwd};
                if (run_cnt == {8'd0, cf_fwd}) begin
                    pos_q = POS_HIGH;
                    fwd_on = 1'b0;
                    rev_on = 1'b0;
                    run_cnt = '0;
                    relay_q = RELAY_BRAKE;
                    r.done = 1'b1;
                    busy_q = 1'b0;
                end
            end
            if (rev_on) begin
                run_cnt = run_cnt + 16'd1;
                if (run_cnt == {8'd0, cf_rev}) begin
                    pos_q = POS_LOW;
                    dwell_cnt = '0;
                    fwd_on = 1'b0;
                    rev_on = 1'b0;
                    run_cnt = '0;
                    relay_q = RELAY_BRAKE;
                end
            end
            // dwell already counts the tick on which the reverse run ended
            if (pos_q == POS_LOW && cf_auto) begin
                dwell_cnt = dwell_cnt + 16'd1;
                if (dwell_cnt == cf_dwell) begin
                    dwell_cnt = '0;
                    run_cnt = '0;
                    pos_q = POS_UNKNOWN;
                    relay_q = RELAY_FWD;
                    fwd_on = 1'b1;
                    rev_on = 1'b0;
                end
            end
        end
        r.relay = relay_q;
        r.pos = pos_q;
        r.busy = busy_q;
        r.mv = mv[15:0];
        return r;
    endfunction

    function automatic void note_error(input string what, input lift_beat_t want,
                                       input lift_beat_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp relay=%0d pos=%0d busy=%0b ack=%0b done=%0b mv=%0d",
                     $realtime, what, want.relay, want.pos, want.busy, want.ack, want.done,
                     want.mv);
            $display("    got relay=%0d pos=%0d busy=%0b ack=%0b done=%0b mv=%0d",
                     got.relay, got.pos, got.busy, got.ack, got.done, got.mv);
        end
    endfunction

    function automatic void add_beat(input logic req, input logic [9:0] adc, input bit typed,
                                     input lift_beat_t exp_v);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.req = req;
        row.adc = adc;
        row.typed = typed;
        row.exp_v = exp_v;
        plan_q.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [7:0] f, input logic [7:0] r, input logic a,
                                    input logic [15:0] d, input logic [15:0] o);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.f = f;
        row.r = r;
        row.a = a;
        row.d = d;
        row.o = o;
        plan_q.push_back(row);
    endfunction

    task automatic drive_request(input logic req, input logic [9:0] adc);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {6'd0, adc};
        do @(posedge aclk); while (!s_tready);
        expected_beats.push_back(predict_lift_beat(req, adc));
        beats_sent++;
        if (req == REQ_LOWER) lowers_sent++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [7:0] f, input logic [7:0] r, input logic a,
                              input logic [15:0] d, input logic [15:0] o);
        wait_all_results();
        write_reg(CFG_FWD_TICKS, {8'd0, f});
        write_reg(CFG_REV_TICKS, {8'd0, r});
        write_reg(CFG_AUTO_RETURN, {15'd0, a});
        write_reg(CFG_DWELL_TICKS, d);
        write_reg(CFG_OVERCURRENT, o);
        cfg_valid <= 1'b0;
        cf_fwd = f;
        cf_rev = r;
        cf_auto = a;
        cf_dwell = d;
        cf_oc = o;
        settings_used++;
    endtask

    // mostly full lower/dwell/raise cycles, some cut short by a new lower, plus noise
    task automatic random_phase(input int n_items);
        int sent;
        int len;
        int k;
        int cut;
        sent = 0;
        while (sent < n_items) begin
            send_gap_pct = gap_choice[$urandom_range(0, 2)];
            sink_gap_pct = gap_choice[$urandom_range(0, 2)];
            k = $urandom_range(0, 9);
            if (k <= 6) begin
                len = cf_rev + (cf_auto ? cf_dwell + cf_fwd : 0) + $urandom_range(0, 4);
                if (len > 600) len = 600;
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
                drive_request(REQ_LOWER, 10'($urandom));
                for (int i = 1; i <= len; i++) begin
                    if (i == cut) begin
                        drive_request(REQ_LOWER, 10'($urandom));
                    end else if ($urandom_range(0, 7) == 0) begin
                        drive_request(REQ_TICK, 10'($urandom_range(880, 1023)));
                    end else begin
                        drive_request(REQ_TICK, 10'($urandom));
                    end
                end
                sent += len + 1;
            end else if (k <= 8) begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    drive_request(($urandom_range(0, 3) == 0) ? REQ_LOWER : REQ_TICK,
                                  10'($urandom));
                end
                sent += len;
            end else begin
                wait_all_results();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_gap_pct) begin
            stall_left <= $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        lift_beat_t got;
        lift_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.relay = m_tdata[3:0];
            got.pos = pos_t'(m_tdata[5:4]);
            got.busy = m_tdata[6];
            got.ack = m_tdata[7];
            got.done = m_tdata[8];
            got.mv = m_tdata[24:9];
            if (got.done === 1'b1) raises_seen++;
            if (expected_beats.size() == 0) begin
                note_error("beat with nothing expected", got, got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) note_error("result mismatch", want, got);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", expected_beats.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // sensor extremes from the reset state
        add_beat(REQ_TICK, 10'd0, 1'b1,
                 '{RELAY_OFF, POS_UNKNOWN, 1'b0, 1'b0, 1'b0, -16'sd20000});
        add_beat(REQ_TICK, 10'd1023, 1'b1,
                 '{RELAY_OFF, POS_UNKNOWN, 1'b0, 1'b0, 1'b0, 16'sd19999});
        add_beat(REQ_TICK, 10'd102, 1'b0, BY_PREDICTOR);
        add_beat(REQ_TICK, 10'd103, 1'b0, BY_PREDICTOR);
        add_beat(REQ_TICK, 10'd921, 1'b0, BY_PREDICTOR);
        add_cfg(8'd4, 8'd2, 1'b1, 16'd2, 16'd0);
        // lower, then lower again while reversing
        add_beat(REQ_LOWER, 10'd0, 1'b1, LOWER_ACK);
        add_beat(REQ_LOWER, 10'd1023, 1'b1, LOWER_ACK);
        add_beat(REQ_TICK, 10'd512, 1'b0, BY_PREDICTOR);
        add_beat(REQ_TICK, 10'd300, 1'b0, BY_PREDICTOR);
        add_beat(REQ_TICK, 10'd700, 1'b0, BY_PREDICTOR);
        // overcurrent at half the run ends the raise early
        add_beat(REQ_TICK, 10'd0, 1'b0, BY_PREDICTOR);
        add_beat(REQ_TICK, 10'd1023, 1'b0, BY_PREDICTOR);
        add_beat(REQ_LOWER, 10'd5, 1'b1, LOWER_ACK);
        repeat (4) add_beat(REQ_TICK, 10'd0, 1'b0, BY_PREDICTOR);
        // lower in the middle of a raise
        add_beat(REQ_LOWER, 10'd0, 1'b1, LOWER_ACK);
        repeat (7) add_beat(REQ_TICK, 10'd0, 1'b0, BY_PREDICTOR);
        add_cfg(8'd4, 8'd2, 1'b0, 16'd2, 16'd0);
        add_beat(REQ_LOWER, 10'd0, 1'b1, LOWER_ACK);
        repeat (3) add_beat(REQ_TICK, 10'd800, 1'b0, BY_PREDICTOR);

        send_gap_pct = 30;
        sink_gap_pct = 30;
        foreach (plan_q[i]) begin
            if (plan_q[i].is_cfg) begin
                set_config(plan_q[i].f, plan_q[i].r, plan_q[i].a, plan_q[i].d, plan_q[i].o);
            end else begin
                drive_request(plan_q[i].req, plan_q[i].adc);
                if (plan_q[i].typed) expected_beats[$] = plan_q[i].exp_v;
            end
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(FWD_TICKS_RST, REV_TICKS_RST, AUTO_RETURN_RST, DWELL_TICKS_RST,
                              OVERCURRENT_RST);
                1: set_config(8'd255, 8'd255, 1'b1, 16'd1, 16'sd19999);
                2: set_config(8'd0, 8'd1, 1'b1, 16'd1, -16'sd20000);
                3: set_config(8'd1, 8'd1, 1'b0, 16'd65535, 16'd0);
                default: set_config(8'($urandom_range(0, 40)), 8'($urandom_range(1, 20)),
                                    ($urandom_range(0, 3) != 0), 16'($urandom_range(1, 40)),
                                    16'($urandom_range(0, 39999) - 20000));
            endcase
            random_phase(150);
        end

        // gapless tail: full lower/dwell/raise cycles with both sides always ready
        send_gap_pct = 0;
        sink_gap_pct = 0;
        set_config(8'd6, 8'd3, 1'b1, 16'd4, 16'd0);
        drive_request(REQ_LOWER, 10'd0);
        repeat (150) drive_request(REQ_TICK, 10'($urandom));

        wait_all_results();
        repeat (8) @(posedge aclk);
        $display("Ran %0d beats (%0d lower commands) under %0d register settings;",
                 beats_sent, lowers_sent, settings_used);
        $display("saw %0d completed raises, ending with a gapless back-to-back stretch",
                 raises_seen);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tlms_pkg.sv
design/tlms_scale.sv
design/tlms_ctrl.sv
design/timed_lift_motor_sequencer_top.sv
design/tlms_checker.sv
sim/timed_lift_motor_sequencer_top_test.sv
